FILE: hw/rtl/rcspc_pkg.sv
// shared types and constants for the rc servo pulse capture block
package rcspc_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int PIN_BITS         = 4;
	localparam int TIMER_W          = 16;
	localparam int COUNT_W          = 8;
	localparam int CFG_INDEX_W      = 2;
	localparam int CFG_DATA_W       = 16;

	localparam logic [COUNT_W-1:0] ALIVE_THRESHOLD_RST = 8'd5;
	localparam logic [TIMER_W-1:0] CENTER_WIDTH_RST    = 16'd3000;
	localparam logic [TIMER_W-1:0] TIMER_TOP_RST       = 16'd40000;
	localparam logic [TIMER_W-1:0] WRAP_LIMIT_RST      = 16'd10000;

	typedef enum logic {
		REQ_PIN   = 1'b0,
		REQ_CHECK = 1'b1
	} req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_CENTER    = 2'd1,
		CFG_TOP       = 2'd2,
		CFG_LIMIT     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [COUNT_W-1:0] alive_threshold;
		logic [TIMER_W-1:0] center_width;
		logic [TIMER_W-1:0] timer_top;
		logic [TIMER_W-1:0] wrap_limit;
	} cfg_t;

	typedef struct packed {
		logic link_ok;
		logic changed;
		logic up_event;
	} link_t;

endpackage

FILE: hw/rtl/rcspc_lane.sv
// one channel lane: edge detect, width capture, alive count
module rcspc_lane
	import rcspc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               is_check,
	input  logic               level_now,
	input  logic               level_was,
	input  logic [TIMER_W-1:0] tmr,
	input  cfg_t               cfg,
	output logic               ok,
	output logic [TIMER_W-1:0] width_nxt
);

	logic [TIMER_W-1:0] rise_q;
	logic [TIMER_W-1:0] width_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIMER_W-1:0] rise_nxt;
	logic [COUNT_W-1:0] count_nxt;
	logic [TIMER_W-1:0] raw_w;
	logic [TIMER_W-1:0] fix_w;

	always_comb begin
		raw_w     = tmr - rise_q;
		// subtracting 65536 - top is adding top modulo 65536
		fix_w     = (raw_w > cfg.wrap_limit) ? raw_w + cfg.timer_top : raw_w;
		ok        = count_q > cfg.alive_threshold;
		rise_nxt  = rise_q;
		width_nxt = width_q;
		count_nxt = count_q;
		if (is_check) begin
			count_nxt = '0;
			if (!ok) begin
				width_nxt = cfg.center_width;
			end
		end else if (level_now != level_was) begin
			if (level_now) begin
				rise_nxt = tmr;
			end else begin
				width_nxt = fix_w;
				count_nxt = count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= '0;
			width_q <= '0;
			count_q <= '0;
		end else if (step) begin
			rise_q  <= rise_nxt;
			width_q <= width_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

FILE: hw/rtl/rcspc_merge.sv
// merging stage: combines lane ok flags into link state
module rcspc_merge
	import rcspc_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    is_check,
	input  logic [NUM_CHANNELS-1:0] lane_ok,
	output logic [NUM_CHANNELS-1:0] ok_mask_nxt,
	output link_t                   link_nxt
);

	logic [NUM_CHANNELS-1:0] channel_ok_q;
	logic                    link_prev_q;
	logic                    all_ok;

	always_comb begin
		all_ok = &lane_ok;
		if (is_check) begin
			ok_mask_nxt       = lane_ok;
			link_nxt.link_ok  = all_ok;
			link_nxt.changed  = all_ok != link_prev_q;
			link_nxt.up_event = (all_ok != link_prev_q) && all_ok;
		end else begin
			ok_mask_nxt       = channel_ok_q;
			link_nxt.link_ok  = link_prev_q;
			link_nxt.changed  = 1'b0;
			link_nxt.up_event = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_ok_q <= '0;
			link_prev_q  <= 1'b0;
		end else if (step && is_check) begin
			channel_ok_q <= lane_ok;
			link_prev_q  <= all_ok;
		end
	end

endmodule

FILE: hw/rtl/rc_servo_pulse_capture.sv
// top level of the rc servo pulse capture block
// output: each accepted input word yields a registered result word
// throughput: one input word per cycle; a two-word output buffer keeps input
// ready while one result waits, so input stalls only when both are full
// reset: clears edge, stamp, width, count and link state, loads register defaults
module rc_servo_pulse_capture
	import rcspc_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   req_type,
	input  logic [PIN_BITS-1:0]    pin_levels,
	input  logic [TIMER_W-1:0]     timer_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [TIMER_W-1:0]     width_ch1,
	output logic [TIMER_W-1:0]     width_ch2,
	output logic [TIMER_W-1:0]     width_ch3,
	output logic [TIMER_W-1:0]     width_ch4,
	output logic [PIN_BITS-1:0]    ok_mask,
	output logic                   link_ok,
	output logic                   link_changed,
	output logic                   link_up_event,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                                  cfg_q;
	logic [PIN_BITS-1:0]                   prev_levels_q;
	logic                                  accept;
	logic                                  is_check;
	logic [NUM_CHANNELS-1:0]               level_now;
	logic [NUM_CHANNELS-1:0]               level_was;
	logic [NUM_CHANNELS-1:0]               lane_ok;
	logic [NUM_CHANNELS-1:0][TIMER_W-1:0]  width_nxt;
	logic [NUM_CHANNELS-1:0]               ok_mask_nxt;
	link_t                                 link_nxt;

	logic                                  out_valid_q;
	logic [NUM_CHANNELS-1:0][TIMER_W-1:0]  out_width_q;
	logic [NUM_CHANNELS-1:0]               out_mask_q;
	link_t                                 out_link_q;
	logic                                  skid_valid_q;
	logic [NUM_CHANNELS-1:0][TIMER_W-1:0]  skid_width_q;
	logic [NUM_CHANNELS-1:0]               skid_mask_q;
	link_t                                 skid_link_q;

	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign is_check  = req_type == REQ_CHECK;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alive_threshold <= ALIVE_THRESHOLD_RST;
			cfg_q.center_width    <= CENTER_WIDTH_RST;
			cfg_q.timer_top       <= TIMER_TOP_RST;
			cfg_q.wrap_limit      <= WRAP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: cfg_q.alive_threshold <= cfg_data[COUNT_W-1:0];
				CFG_CENTER:    cfg_q.center_width    <= cfg_data[TIMER_W-1:0];
				CFG_TOP:       cfg_q.timer_top       <= cfg_data[TIMER_W-1:0];
				CFG_LIMIT:     cfg_q.wrap_limit      <= cfg_data[TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
		end else if (accept && !is_check) begin
			prev_levels_q <= pin_levels;
		end
	end

	for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
		// channels beyond the pin bits see a constant low level
		if (ch < PIN_BITS) begin : g_pin
			assign level_now[ch] = pin_levels[ch];
			assign level_was[ch] = prev_levels_q[ch];
		end else begin : g_nopin
			assign level_now[ch] = 1'b0;
			assign level_was[ch] = 1'b0;
		end

		rcspc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (accept),
			.is_check  (is_check),
			.level_now (level_now[ch]),
			.level_was (level_was[ch]),
			.tmr       (timer_value),
			.cfg       (cfg_q),
			.ok        (lane_ok[ch]),
			.width_nxt (width_nxt[ch])
		);
	end

	rcspc_merge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.is_check    (is_check),
		.lane_ok     (lane_ok),
		.ok_mask_nxt (ok_mask_nxt),
		.link_nxt    (link_nxt)
	);

	// output register with skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_width_q <= skid_width_q;
				out_mask_q  <= skid_mask_q;
				out_link_q  <= skid_link_q;
			end
		end else if (accept) begin
			if (out_valid_q && !out_ready) begin
				skid_width_q <= width_nxt;
				skid_mask_q  <= ok_mask_nxt;
				skid_link_q  <= link_nxt;
			end else begin
				out_width_q <= width_nxt;
				out_mask_q  <= ok_mask_nxt;
				out_link_q  <= link_nxt;
			end
		end
	end

	logic [PIN_BITS-1:0][TIMER_W-1:0] width_port;

	for (genvar k = 0; k < PIN_BITS; k++) begin : g_port
		if (k < NUM_CHANNELS) begin : g_used
			assign width_port[k] = out_width_q[k];
			assign ok_mask[k]    = out_mask_q[k];
		end else begin : g_unused
			assign width_port[k] = '0;
			assign ok_mask[k]    = 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign width_ch1     = width_port[0];
	assign width_ch2     = width_port[1];
	assign width_ch3     = width_port[2];
	assign width_ch4     = width_port[3];
	assign link_ok       = out_link_q.link_ok;
	assign link_changed  = out_link_q.changed;
	assign link_up_event = out_link_q.up_event;

endmodule
